// File: sv/cscm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the cell staleness cost map.
// No dependencies; every other file of the block imports this package.
package cscm_pkg;

	// Payload widths
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned CELL_W  = 16;
	localparam int unsigned COST_W  = 7;
	localparam int unsigned SLOPE_W = 24;
	localparam int unsigned CELLS_W = 17;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned PROD_W  = STAMP_W + SLOPE_W;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AGE_THRESHOLD = 2'd0,
		REG_COST_SLOPE    = 2'd1,
		REG_MAP_CELLS     = 2'd2
	} cfg_reg_t;

	localparam logic [STAMP_W-1:0] AGE_THRESHOLD_RST = 32'd0;
	localparam logic [SLOPE_W-1:0] COST_SLOPE_RST    = 24'd65536;
	localparam logic [CELLS_W-1:0] MAP_CELLS_RST     = 17'd65536;

	// Item actions
	localparam logic ACT_MARK  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Cost of a cell never seen, and the clamp of every cost
	localparam logic [COST_W-1:0] COST_MAX = 7'd100;

	// Default grid size
	localparam int unsigned GRID_CELLS_DEF = 65536;

endpackage

// File: sv/cscm_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the cell staleness cost map.
// Depends on cscm_pkg for the payload widths.

interface cscm_item_if import cscm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                action;
	logic [CELL_W-1:0]   cell_index;
	logic [STAMP_W-1:0]  now_ms;

	modport source (output valid, action, cell_index, now_ms, input ready);
	modport sink   (input valid, action, cell_index, now_ms, output ready);
endinterface

interface cscm_result_if import cscm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COST_W-1:0]  cost;
	logic               out_of_range;

	modport source (output valid, cost, out_of_range, input ready);
	modport sink   (input valid, cost, out_of_range, output ready);
endinterface

// File: sv/cell_staleness_cost_map.sv
`timescale 1ns / 1ps
// Top level of the cell staleness cost map: timestamp memory, cost datapath, config registers.
// Depends on cscm_pkg and on the channel interfaces in cscm_ifs.sv.
//
// The block keeps one word per grid cell in a single synchronous memory: a seen bit and the
// time of the last mark. A mark transaction stores now_ms for the cell; a query transaction
// answers the cell's cost: 100 if never seen, 0 if its age (now_ms minus the stamp, modulo
// 2^32) is at or below age_threshold_ms, else floor(excess age * cost_slope / 2^16) clamped
// at 100. An index at or beyond min(map_cells, GRID_CELLS) sets out_of_range, skips the write
// of a mark and answers cost 0. Items are handled one at a time: a mark or an out-of-range
// item goes from acceptance straight to the output register; an in-range query steps through
// accept with memory read, age subtract, threshold compare and subtract, 32x24 multiply and
// clamp into the output register. The next item is accepted in the cycle after the load, also
// while that result still waits there. After reset a clearing pass drops the seen bit of every
// entry, one entry a cycle, so no item is accepted until it ends; configuration writes are
// taken at any time, but only while the block is idle do they give defined results.
module cell_staleness_cost_map import cscm_pkg::*; #(
	parameter int unsigned GRID_CELLS = GRID_CELLS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	cscm_item_if.sink             item,
	cscm_result_if.source         result
);

	localparam int unsigned AW = $clog2(GRID_CELLS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(GRID_CELLS - 1);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_AGE   = 6'b001000,
		ST_MUL   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [STAMP_W-1:0] age_threshold_q;
	logic [SLOPE_W-1:0] cost_slope_q;
	logic [CELLS_W-1:0] map_cells_q;

	// Timestamp memory: {seen, stamp}
	logic [STAMP_W:0]   stamp_mem_q [GRID_CELLS];
	logic [STAMP_W:0]   mem_rd_s1;
	logic               mem_we;
	logic               mem_re;
	logic [AW-1:0]      mem_addr;
	logic [STAMP_W:0]   mem_wdata;
	logic [AW-1:0]      clr_q;

	// Held item
	logic               act_q;
	logic               oor_q;
	logic [STAMP_W-1:0] now_q;

	// Datapath stages
	logic [STAMP_W-1:0] age_s2;
	logic               seen_s2;
	logic [STAMP_W-1:0] excess_s3;
	logic               above_s3;
	logic               seen_s3;
	logic [PROD_W-1:0]  prod_s4;
	logic               above_s4;
	logic               seen_s4;

	// Output register
	logic               out_valid_q;
	logic [COST_W-1:0]  out_cost_q;
	logic               out_oor_q;

	logic               in_oor;
	logic               in_fire;
	logic               out_load;
	logic [COST_W-1:0]  cost_nxt;
	logic [PROD_W-FRAC_W-1:0] scaled;

	// Hold the registers; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_threshold_q <= AGE_THRESHOLD_RST;
			cost_slope_q    <= COST_SLOPE_RST;
			map_cells_q     <= MAP_CELLS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_AGE_THRESHOLD: age_threshold_q <= cfg_wdata[STAMP_W-1:0];
				REG_COST_SLOPE:    cost_slope_q    <= cfg_wdata[SLOPE_W-1:0];
				REG_MAP_CELLS:     map_cells_q     <= cfg_wdata[CELLS_W-1:0];
				default: ;
			endcase
		end
	end

	// Range check against both the configured size and the physical grid.
	assign in_oor = ({1'b0, item.cell_index} >= map_cells_q) ||
	                (32'(item.cell_index) >= 32'(GRID_CELLS));

	assign item.ready = (state_q == ST_IDLE);
	assign in_fire    = item.valid && item.ready;
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || result.ready);

	// One memory access a cycle: clearing writes, or the access of an accepted item.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_addr  = clr_q;
			mem_we    = 1'b1;
			mem_re    = 1'b0;
			mem_wdata = '0;
		end else begin
			mem_addr  = AW'(item.cell_index);
			mem_we    = in_fire && !in_oor && (item.action == ACT_MARK);
			mem_re    = in_fire && !in_oor && (item.action == ACT_QUERY);
			mem_wdata = {1'b1, item.now_ms};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stamp_mem_q[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rd_s1 <= stamp_mem_q[mem_addr];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= (in_oor || item.action == ACT_MARK) ? ST_OUT : ST_READ;
					end
				end
				ST_READ: state_q <= ST_AGE;
				ST_AGE:  state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the item at acceptance.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_q <= item.action;
			oor_q <= in_oor;
			now_q <= item.now_ms;
		end
	end

	// Age, threshold, slope: one wide operation per stage.
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			age_s2  <= now_q - mem_rd_s1[STAMP_W-1:0];
			seen_s2 <= mem_rd_s1[STAMP_W];
		end
		if (state_q == ST_AGE) begin
			excess_s3 <= age_s2 - age_threshold_q;
			above_s3  <= age_s2 > age_threshold_q;
			seen_s3   <= seen_s2;
		end
		if (state_q == ST_MUL) begin
			prod_s4  <= PROD_W'(excess_s3) * PROD_W'(cost_slope_q);
			above_s4 <= above_s3;
			seen_s4  <= seen_s3;
		end
	end

	// Clamp the scaled product; never-seen cells cost the most, marks and out-of-range items zero.
	assign scaled = prod_s4[PROD_W-1:FRAC_W];

	always_comb begin
		if (act_q == ACT_MARK || oor_q) begin
			cost_nxt = '0;
		end else if (!seen_s4) begin
			cost_nxt = COST_MAX;
		end else if (!above_s4) begin
			cost_nxt = '0;
		end else if (scaled > (PROD_W-FRAC_W)'(COST_MAX)) begin
			cost_nxt = COST_MAX;
		end else begin
			cost_nxt = scaled[COST_W-1:0];
		end
	end

	// Output register: load from the last stage, drop on the downstream transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_cost_q <= cost_nxt;
			out_oor_q  <= oor_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.cost         = out_cost_q;
	assign result.out_of_range = out_oor_q;

	// No item is taken while the clearing pass runs.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !item.ready)
		else $error("item accepted during clearing pass");

	// Outside the clearing pass only an in-range mark writes the memory.
	a_write_only_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q != ST_CLEAR) |-> (item.action == ACT_MARK && !in_oor && in_fire))
		else $error("memory written by a non-mark transaction");

	// A new result appears only out of the final stage.
	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output stage");

	// A waiting result is not overwritten before it is taken.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> (result.valid && $stable(result.cost)
		&& $stable(result.out_of_range)))
		else $error("pending result changed");

endmodule

// File: test/cell_staleness_cost_map_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the cell staleness cost map: stimulus table, random traffic, shadow map.
// Depends on cscm_pkg, the channel interfaces in cscm_ifs.sv and the cell_staleness_cost_map RTL.

module cell_staleness_cost_map_test;
	import cscm_pkg::*;

	localparam int unsigned GRID           = GRID_CELLS_DEF;
	// Stimulus phases after the table, each with its own register setting
	localparam int          RANDOM_PHASES  = 7;
	localparam int          ITEMS_PER_PHASE = 120;
	// Wait after the last expected result before a register write, so the block is idle
	localparam int          SETTLE_CYCLES  = 8;
	// The clearing pass after reset holds off every transaction; the limit is a multiple of GRID
	localparam int          WATCHDOG_LIMIT = 4 * GRID;
	localparam int          MAX_PRINTED    = 40;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic              oor;
	} cost_rec_t;

	typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic                  act;
		logic [CELL_W-1:0]     cell_idx;
		logic [CFG_DATA_W-1:0] value;   // now_ms of an item, write data of a register row
		cfg_reg_t              sel;
		bit                    typed;   // expected result written into the table
		cost_rec_t             want;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	cscm_item_if   item_ch ();
	cscm_result_if result_ch ();

	cell_staleness_cost_map dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the block: register copies and the per-cell stamp store
	logic [STAMP_W-1:0] age_limit;
	logic [SLOPE_W-1:0] slope_q16;
	logic [CELLS_W-1:0] map_cells_r;
	logic [STAMP_W-1:0] stamp_shadow [GRID];
	bit                 seen_shadow  [GRID];

	cost_rec_t          expected_costs [$];
	logic [CELL_W-1:0]  marked_cells [$];   // cells recently marked in range, for follow-up queries and re-marks
	script_row_t        script [$];

	int error_count;
	int burst_left;
	int n_marks, n_queries, n_oor, n_zero, n_partial, n_clamped, n_settings;

	task automatic flag_mismatch(input string msg);
		if (error_count < MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic int unsigned map_limit();
		return (map_cells_r > GRID) ? GRID : int'(map_cells_r);
	endfunction

	// Apply one accepted item to the shadow map and return the result it must produce.
	function automatic cost_rec_t predict_cost(input logic act, input logic [CELL_W-1:0] cell_idx,
			input logic [STAMP_W-1:0] now);
		cost_rec_t          r;
		logic [STAMP_W-1:0] age;
		logic [PROD_W-1:0]  scaled;
		r.cost = '0;
		r.oor  = (cell_idx >= map_limit());
		if (r.oor) begin
			n_oor++;
		end else if (act == ACT_MARK) begin
			stamp_shadow[cell_idx] = now;
			seen_shadow[cell_idx]  = 1'b1;
			marked_cells.insert(marked_cells.size(), cell_idx);
			if (marked_cells.size() > 24)
				void'(marked_cells.pop_front());
		end else if (!seen_shadow[cell_idx]) begin
			r.cost = COST_MAX;
		end else begin
			age = now - stamp_shadow[cell_idx];
			if (age > age_limit) begin
				scaled = (PROD_W'(age - age_limit) * PROD_W'(slope_q16)) >> FRAC_W;
				r.cost = (scaled > PROD_W'(COST_MAX)) ? COST_MAX : scaled[COST_W-1:0];
			end
		end
		if (act == ACT_MARK) begin
			n_marks++;
		end else begin
			n_queries++;
			if (!r.oor) begin
				if (r.cost == 0)
					n_zero++;
				else if (r.cost == COST_MAX)
					n_clamped++;
				else
					n_partial++;
			end
		end
		return r;
	endfunction

	function automatic void add_item(input logic act, input logic [CELL_W-1:0] cell_idx,
			input logic [STAMP_W-1:0] now, input bit typed, input logic [COST_W-1:0] cost,
			input logic oor);
		script_row_t row;
		row.kind     = ROW_ITEM;
		row.act      = act;
		row.cell_idx = cell_idx;
		row.value    = now;
		row.sel      = REG_AGE_THRESHOLD;
		row.typed    = typed;
		row.want     = '{cost: cost, oor: oor};
		script.insert(script.size(), row);
	endfunction

	function automatic void add_write(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
		script_row_t row;
		row.kind     = ROW_WRITE;
		row.act      = ACT_MARK;
		row.cell_idx = '0;
		row.value    = data;
		row.sel      = sel;
		row.typed    = 1'b0;
		row.want     = '0;
		script.insert(script.size(), row);
	endfunction

	// Write one register at the next edge; the caller drops the write enable after its batch.
	task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= data;
		@(posedge clk);
		case (sel)
			REG_AGE_THRESHOLD: age_limit   = data;
			REG_COST_SLOPE:    slope_q16   = data[SLOPE_W-1:0];
			REG_MAP_CELLS:     map_cells_r = data[CELLS_W-1:0];
			default: ;
		endcase
	endtask

	// Offer one transaction, holding it until accepted; insert a gap when the burst runs out.
	task automatic send_item(input logic act, input logic [CELL_W-1:0] cell_idx,
			input logic [STAMP_W-1:0] now, input bit typed, input cost_rec_t want);
		cost_rec_t predicted;
		if (burst_left <= 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
			                                          : $urandom_range(1, 12);
		end
		item_ch.valid      <= 1'b1;
		item_ch.action     <= act;
		item_ch.cell_index <= cell_idx;
		item_ch.now_ms     <= now;
		do @(posedge clk); while (!item_ch.ready);
		burst_left--;
		predicted = predict_cost(act, cell_idx, now);
		expected_costs.insert(expected_costs.size(), typed ? want : predicted);
	endtask

	// Drop valid and wait until the block has answered everything and gone quiet.
	task automatic settle();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_costs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: stall on a pattern of its own and check each transaction against the oldest
	// expectation. Modes switch between always ready, random stalls and a rotating bit pattern.
	initial begin : result_side
		int        mode;
		int        mode_left;
		int        pat_pos;
		bit [15:0] stall_pat;
		cost_rec_t want;
		mode      = 0;
		mode_left = 0;
		pat_pos   = 0;
		stall_pat = '1;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				if (expected_costs.size() == 0) begin
					flag_mismatch($sformatf("result cost=%0d oor=%0b with nothing expected",
						result_ch.cost, result_ch.out_of_range));
				end else begin
					want = expected_costs.pop_front();
					if (result_ch.cost !== want.cost)
						flag_mismatch($sformatf("cost %0d, expected %0d",
							result_ch.cost, want.cost));
					if (result_ch.out_of_range !== want.oor)
						flag_mismatch($sformatf("out_of_range %0b, expected %0b",
							result_ch.out_of_range, want.oor));
				end
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 300);
				stall_pat = 16'($urandom) | 16'h0001;
			end
			mode_left--;
			pat_pos = (pat_pos + 1) % 16;
			case (mode)
				0:       result_ch.ready <= 1'b1;
				1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
				default: result_ch.ready <= stall_pat[pat_pos];
			endcase
		end
	end

	// Watchdog: end the run when no transaction moves on either channel for too long.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", idle_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		logic                  act;
		logic [CELL_W-1:0]     cell_idx;
		logic [STAMP_W-1:0]    now;
		logic [CFG_DATA_W-1:0] thr_w, slope_w, cells_w;
		longint                span;
		int unsigned           lim;
		int                    pick;

		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_index          = REG_AGE_THRESHOLD;
		cfg_wdata          = '0;
		item_ch.valid      = 1'b0;
		item_ch.action     = ACT_MARK;
		item_ch.cell_index = '0;
		item_ch.now_ms     = '0;
		error_count        = 0;
		burst_left         = 0;
		n_settings         = 1;
		age_limit          = AGE_THRESHOLD_RST;
		slope_q16          = COST_SLOPE_RST;
		map_cells_r        = MAP_CELLS_RST;
		for (int i = 0; i < GRID; i++)
			seen_shadow[i] = 1'b0;

		// Directed table, run at the reset setting: threshold 0, slope 1.0, full map.
		// Never-seen cells, then a mark and queries walking up to and past the clamp.
		add_item(ACT_QUERY, 16'd0,     32'd0,          1, 7'd100, 1'b0);
		add_item(ACT_QUERY, 16'hFFFF,  32'hFFFF_FFFF,  1, 7'd100, 1'b0);
		add_item(ACT_MARK,  16'd0,     32'd1000,       1, 7'd0,   1'b0);
		add_item(ACT_QUERY, 16'd0,     32'd1000,       1, 7'd0,   1'b0);
		add_item(ACT_QUERY, 16'd0,     32'd1001,       1, 7'd1,   1'b0);
		add_item(ACT_QUERY, 16'd0,     32'd1100,       1, 7'd100, 1'b0);
		add_item(ACT_QUERY, 16'd0,     32'd1101,       1, 7'd100, 1'b0);
		// Query just before the stamp: age wraps to all ones
		add_item(ACT_QUERY, 16'd0,     32'd999,        1, 7'd100, 1'b0);
		// Stamp at the top of the time range, query across the wrap
		add_item(ACT_MARK,  16'hFFFF,  32'hFFFF_FFFF,  1, 7'd0,   1'b0);
		add_item(ACT_QUERY, 16'hFFFF,  32'd0,          1, 7'd1,   1'b0);
		add_item(ACT_QUERY, 16'hFFFF,  32'd49,         0, 7'd0,   1'b0);
		add_item(ACT_MARK,  16'h5555,  32'hAAAA_AAAA,  0, 7'd0,   1'b0);
		add_item(ACT_QUERY, 16'h5555,  32'hAAAA_AACF,  0, 7'd0,   1'b0);
		add_item(ACT_MARK,  16'hAAAA,  32'h5555_5555,  0, 7'd0,   1'b0);
		add_item(ACT_QUERY, 16'hAAAA,  32'h5555_55B8,  0, 7'd0,   1'b0);
		// Re-mark overwrites the stamp
		add_item(ACT_MARK,  16'd0,     32'd0,          0, 7'd0,   1'b0);
		add_item(ACT_QUERY, 16'd0,     32'd64,         0, 7'd0,   1'b0);
		// One-cell map: index 1 is out of range, its mark is dropped
		add_write(REG_MAP_CELLS, 32'd1);
		add_item(ACT_QUERY, 16'd0,     32'd64,         0, 7'd0,   1'b0);
		add_item(ACT_QUERY, 16'd1,     32'd0,          1, 7'd0,   1'b1);
		add_item(ACT_MARK,  16'd1,     32'd5,          1, 7'd0,   1'b1);
		// Empty map: every index is out of range
		add_write(REG_MAP_CELLS, 32'd0);
		add_item(ACT_QUERY, 16'd0,     32'd0,          1, 7'd0,   1'b1);
		// Full map again, threshold 10, slope 2.0
		add_write(REG_MAP_CELLS, 32'd65536);
		add_write(REG_AGE_THRESHOLD, 32'd10);
		add_write(REG_COST_SLOPE, 32'h0002_0000);
		add_item(ACT_QUERY, 16'd1,     32'd6,          1, 7'd100, 1'b0);
		add_item(ACT_QUERY, 16'd0,     32'd10,         1, 7'd0,   1'b0);
		add_item(ACT_QUERY, 16'd0,     32'd20,         0, 7'd0,   1'b0);
		add_item(ACT_QUERY, 16'd0,     32'd74,         1, 7'd100, 1'b0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				if (i == 0 || script[i-1].kind != ROW_WRITE) begin
					settle();
					n_settings++;
				end
				write_reg(script[i].sel, script[i].value);
				if (i + 1 == script.size() || script[i+1].kind != ROW_WRITE)
					cfg_wr_en <= 1'b0;
			end else begin
				send_item(script[i].act, script[i].cell_idx, script[i].value,
					script[i].typed, script[i].want);
			end
		end

		// Random phases. Registers go through their extremes, values past their width,
		// a shrink to a small map and a regrow where earlier stamps must survive.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			case (ph)
				0: begin
					thr_w = 32'd0;  slope_w = 32'h00FF_FFFF;  cells_w = 32'd65536;
				end
				1: begin
					thr_w = 32'hFFFF_FFFF;  slope_w = 32'h0001_0000;  cells_w = 32'd1;
				end
				2: begin
					thr_w   = $urandom_range(0, 2000);
					slope_w = $urandom_range(32'h100, 32'h4_0000);
					cells_w = 32'd0;
				end
				3: begin
					// upper bits beyond each register's width must be ignored
					thr_w = 32'd0;  slope_w = 32'hFF00_0800;  cells_w = 32'hFFFF_FFFF;
				end
				4: begin
					thr_w = $urandom;  slope_w = 32'd0;  cells_w = $urandom_range(16, 4096);
				end
				5: begin
					thr_w   = $urandom_range(0, 100000);
					slope_w = $urandom_range(0, 32'hFF_FFFF);
					cells_w = 32'd100;
				end
				default: begin
					thr_w   = $urandom_range(0, 500);
					slope_w = $urandom_range(32'h4000, 32'h3_0000);
					cells_w = $urandom_range(65536, 131071);
				end
			endcase
			write_reg(REG_AGE_THRESHOLD, thr_w);
			write_reg(REG_COST_SLOPE, slope_w);
			write_reg(REG_MAP_CELLS, cells_w);
			cfg_wr_en <= 1'b0;
			n_settings++;

			repeat (ITEMS_PER_PHASE) begin
				lim  = map_limit();
				pick = $urandom_range(0, 99);
				// Span of excess age that covers costs 0 through the clamp at this slope
				span = (slope_q16 == 0) ? 64 : ((longint'(COST_MAX) << FRAC_W) / slope_q16) + 2;
				if (pick < 35) begin
					// mark a random in-range cell at a random time, any cell on an empty map
					act      = ACT_MARK;
					cell_idx = (lim > 0) ? CELL_W'($urandom_range(0, lim - 1))
					                     : CELL_W'($urandom);
					now      = $urandom;
				end else if (pick < 42 && marked_cells.size() > 0) begin
					// mark a recently seen cell again
					act      = ACT_MARK;
					cell_idx = marked_cells[$urandom_range(0, marked_cells.size() - 1)];
					now      = $urandom;
				end else if (pick < 48) begin
					// mark anywhere, often out of range on a small map
					act      = ACT_MARK;
					cell_idx = (lim < GRID && $urandom_range(0, 1) == 1)
						? CELL_W'($urandom_range(lim, GRID - 1)) : CELL_W'($urandom);
					now      = $urandom;
				end else if (pick < 85 && marked_cells.size() > 0) begin
					// query a seen cell at an age around the threshold and the clamp
					act      = ACT_QUERY;
					cell_idx = marked_cells[$urandom_range(0, marked_cells.size() - 1)];
					now      = stamp_shadow[cell_idx] + age_limit;
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: now += STAMP_W'($urandom_range(0, int'(span)));
						6, 7:             now += STAMP_W'(span) + STAMP_W'($urandom_range(0, 5000));
						8:                now -= STAMP_W'($urandom_range(0, 50));
						default:          now += STAMP_W'($urandom_range(0, 1));
					endcase
				end else begin
					// query anything: mostly never-seen or out-of-range cells
					act      = ACT_QUERY;
					cell_idx = CELL_W'($urandom);
					now      = $urandom;
				end
				send_item(act, cell_idx, now, 1'b0, '0);
			end
		end
		settle();

		$display("Covered %0d marks and %0d queries over %0d register settings, %0d out of range.",
			n_marks, n_queries, n_settings, n_oor);
		$display("In-range queries: %0d cost zero, %0d between, %0d at the top cost.",
			n_zero, n_partial, n_clamped);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
